// ----- hdl/mtc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared types, register indexes and arithmetic constants of the motor
// turn-count controller.
// ----------------------------------------------------------------------------
package mtc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_THRESHOLD   = 3'd0;
    localparam logic [2:0] REG_COUNTS_TURN = 3'd1;
    localparam logic [2:0] REG_SLOW_DUTY   = 3'd2;
    localparam logic [2:0] REG_MIDDLE_DUTY = 3'd3;
    localparam logic [2:0] REG_FAST_DUTY   = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    // Configuration reset values
    localparam logic [7:0]  THRESHOLD_RST   = 8'd30;
    localparam logic [10:0] COUNTS_TURN_RST = 11'd1440;
    localparam logic [7:0]  SLOW_DUTY_RST   = 8'd150;
    localparam logic [7:0]  MIDDLE_DUTY_RST = 8'd200;
    localparam logic [7:0]  FAST_DUTY_RST   = 8'd250;

    // Speed levels
    localparam logic [1:0] LVL_SLOW   = 2'd0;
    localparam logic [1:0] LVL_MIDDLE = 2'd1;
    localparam logic [1:0] LVL_FAST   = 2'd2;

    // speed / 1370 on a 12-bit sample is one of three bands
    localparam logic [11:0] SPEED_STEP     = 12'd1370;
    localparam logic [11:0] SPEED_STEP_TWO = 12'd2740;

    // turns / 99 as (turns * 662) >> 16, exact for 12-bit samples
    localparam logic [9:0] TURNS_RECIP = 10'd662;
    localparam int         TURNS_SHIFT = 16;

    // x / 10 as (x * 205) >> 11, exact for 9-bit x
    localparam logic [10:0] TENTH_RECIP = 11'd205;
    localparam int          TENTH_SHIFT = 11;

    localparam int   MAX_TURNS  = 41;
    localparam logic [15:0] EDGE_MAX = 16'hFFFF;
    localparam logic [7:0]  TICK_MAX = 8'hFF;

    typedef struct packed {
        logic [7:0]  trigger_threshold;
        logic [10:0] counts_per_turn;
        logic [7:0]  slow_duty;
        logic [7:0]  middle_duty;
        logic [7:0]  fast_duty;
    } cfg_t;

    typedef struct packed {
        logic [11:0] speed_sample;
        logic [11:0] turns_sample;
        logic        cw_switch;
        logic        ccw_switch;
        logic        encoder_edge;
    } tick_t;

    typedef struct packed {
        logic       forward_drive;
        logic       reverse_drive;
        logic [7:0] drive_duty;
        logic [5:0] turns_set;
        logic [1:0] speed_level;
        logic       busy_res;
    } res_t;

    typedef struct packed {
        logic moving;
        logic hold;
    } status_t;

endpackage

// ----- hdl/mtc_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_in_if
// Tick channel: pot samples, direction switches and encoder edge.
// ----------------------------------------------------------------------------
interface mtc_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] speed_sample;
    logic [11:0] turns_sample;
    logic        cw_switch;
    logic        ccw_switch;
    logic        encoder_edge;

    modport source (
        output valid, speed_sample, turns_sample, cw_switch, ccw_switch, encoder_edge,
        input  ready
    );
    modport sink (
        input  valid, speed_sample, turns_sample, cw_switch, ccw_switch, encoder_edge,
        output ready
    );
endinterface

// ----- hdl/mtc_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_out_if
// Result channel: bridge drive, duty and the displayed settings.
// ----------------------------------------------------------------------------
interface mtc_out_if;
    logic       valid;
    logic       ready;
    logic       forward_drive;
    logic       reverse_drive;
    logic [7:0] drive_duty;
    logic [5:0] turns_set;
    logic [1:0] speed_level;
    logic       busy_res;

    modport source (
        output valid, forward_drive, reverse_drive, drive_duty, turns_set,
               speed_level, busy_res,
        input  ready
    );
    modport sink (
        input  valid, forward_drive, reverse_drive, drive_duty, turns_set,
               speed_level, busy_res,
        output ready
    );
endinterface

// ----- hdl/mtc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module mtc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mtc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mtc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output mtc_pkg::cfg_t                   cfg
);

    mtc_pkg::cfg_t cfg_reg;
    mtc_pkg::cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                mtc_pkg::REG_THRESHOLD:   cfg_next.trigger_threshold = cfg_data[7:0];
                mtc_pkg::REG_COUNTS_TURN: cfg_next.counts_per_turn   = cfg_data[10:0];
                mtc_pkg::REG_SLOW_DUTY:   cfg_next.slow_duty         = cfg_data[7:0];
                mtc_pkg::REG_MIDDLE_DUTY: cfg_next.middle_duty       = cfg_data[7:0];
                mtc_pkg::REG_FAST_DUTY:   cfg_next.fast_duty         = cfg_data[7:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_threshold <= mtc_pkg::THRESHOLD_RST;
            cfg_reg.counts_per_turn   <= mtc_pkg::COUNTS_TURN_RST;
            cfg_reg.slow_duty         <= mtc_pkg::SLOW_DUTY_RST;
            cfg_reg.middle_duty       <= mtc_pkg::MIDDLE_DUTY_RST;
            cfg_reg.fast_duty         <= mtc_pkg::FAST_DUTY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/mtc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_core
// Controller state and the per-tick update: turns filter, speed band,
// switch debounce counters, move start and encoder edge counting.
// ----------------------------------------------------------------------------
module mtc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  mtc_pkg::tick_t    tick,
    input  mtc_pkg::cfg_t     cfg,
    output mtc_pkg::res_t     res,
    output mtc_pkg::status_t  status
);

    logic [5:0]  turns_reg,  turns_next;
    logic        hold_reg,   hold_next;
    logic        cw_dir_reg, cw_dir_next;
    logic [7:0]  cw_ticks_reg,  cw_ticks_next;
    logic [7:0]  ccw_ticks_reg, ccw_ticks_next;
    logic        moving_reg, moving_next;
    logic [15:0] edge_cnt_reg,  edge_cnt_next;
    logic [15:0] edge_lim_reg,  edge_lim_next;
    logic [7:0]  duty_reg,  duty_next;
    logic [1:0]  level_reg, level_next;

    logic [21:0] quot_prod;
    logic [5:0]  quot;
    logic [8:0]  blend;
    logic [19:0] tenth_prod;
    logic [5:0]  turns_new;
    logic [1:0]  level_new;
    logic [7:0]  duty_new;
    logic [16:0] lim_prod;
    logic [15:0] lim_sat;
    logic [15:0] edge_inc;
    logic        hold_off;
    logic [7:0]  cw_cnt, ccw_cnt;

    // Turns filter: q = turns/99, then (3*old + 7*q)/10
    always_comb
    begin
        quot_prod  = {10'd0, tick.turns_sample} * {12'd0, mtc_pkg::TURNS_RECIP};
        quot       = quot_prod[mtc_pkg::TURNS_SHIFT +: 6];
        blend      = ({3'd0, turns_reg} * 9'd3) + ({3'd0, quot} * 9'd7);
        tenth_prod = {11'd0, blend} * {9'd0, mtc_pkg::TENTH_RECIP};
        turns_new  = tenth_prod[mtc_pkg::TENTH_SHIFT +: 6];
    end

    // Speed band and its duty
    always_comb
    begin
        if (tick.speed_sample >= mtc_pkg::SPEED_STEP_TWO)
            level_new = mtc_pkg::LVL_FAST;
        else if (tick.speed_sample >= mtc_pkg::SPEED_STEP)
            level_new = mtc_pkg::LVL_MIDDLE;
        else
            level_new = mtc_pkg::LVL_SLOW;

        case (level_new)
            mtc_pkg::LVL_SLOW:   duty_new = cfg.slow_duty;
            mtc_pkg::LVL_MIDDLE: duty_new = cfg.middle_duty;
            default:             duty_new = cfg.fast_duty;
        endcase
    end

    // Move length, saturated to 16 bits
    always_comb
    begin
        lim_prod = {11'd0, turns_new} * {6'd0, cfg.counts_per_turn};
        lim_sat  = lim_prod[16] ? mtc_pkg::EDGE_MAX : lim_prod[15:0];
    end

    // Next state for one tick
    always_comb
    begin
        turns_next     = turns_reg;
        hold_next      = hold_reg;
        cw_dir_next    = cw_dir_reg;
        cw_ticks_next  = cw_ticks_reg;
        ccw_ticks_next = ccw_ticks_reg;
        moving_next    = moving_reg;
        edge_cnt_next  = edge_cnt_reg;
        edge_lim_next  = edge_lim_reg;
        duty_next      = duty_reg;
        level_next     = level_reg;
        hold_off       = 1'b0;
        cw_cnt         = cw_ticks_reg;
        ccw_cnt        = ccw_ticks_reg;
        edge_inc       = edge_cnt_reg;

        if (moving_reg)
        begin
            // Count encoder edges until the limit
            if (tick.encoder_edge && (edge_cnt_reg != mtc_pkg::EDGE_MAX))
                edge_inc = edge_cnt_reg + 16'd1;
            edge_cnt_next = edge_inc;
            if (edge_inc >= edge_lim_reg)
                moving_next = 1'b0;
        end
        else
        begin
            hold_off   = hold_reg && (tick.cw_switch || tick.ccw_switch);
            hold_next  = hold_off;
            turns_next = turns_new;
            level_next = level_new;
            duty_next  = duty_new;

            // Debounce the switches outside manual mode and hold
            if ((turns_new != 6'd0) && !hold_off)
            begin
                if (!tick.cw_switch && !tick.ccw_switch)
                begin
                    cw_cnt  = 8'd0;
                    ccw_cnt = 8'd0;
                end
                else if (tick.cw_switch && !tick.ccw_switch)
                begin
                    cw_cnt  = (cw_ticks_reg == mtc_pkg::TICK_MAX) ? cw_ticks_reg
                                                                 : cw_ticks_reg + 8'd1;
                    ccw_cnt = 8'd0;
                    cw_dir_next = 1'b1;
                end
                else if (!tick.cw_switch && tick.ccw_switch)
                begin
                    ccw_cnt = (ccw_ticks_reg == mtc_pkg::TICK_MAX) ? ccw_ticks_reg
                                                                  : ccw_ticks_reg + 8'd1;
                    cw_cnt  = 8'd0;
                    cw_dir_next = 1'b0;
                end
                cw_ticks_next  = cw_cnt;
                ccw_ticks_next = ccw_cnt;

                // Start a move once either count reaches the threshold
                if ((cw_cnt >= cfg.trigger_threshold) || (ccw_cnt >= cfg.trigger_threshold))
                begin
                    edge_lim_next = lim_sat;
                    edge_cnt_next = 16'd0;
                    moving_next   = (lim_sat != 16'd0);
                    hold_next     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turns_reg     <= 6'd0;
            hold_reg      <= 1'b1;
            cw_dir_reg    <= 1'b1;
            cw_ticks_reg  <= 8'd0;
            ccw_ticks_reg <= 8'd0;
            moving_reg    <= 1'b0;
            edge_cnt_reg  <= 16'd0;
            edge_lim_reg  <= 16'd0;
            duty_reg      <= 8'd0;
            level_reg     <= mtc_pkg::LVL_SLOW;
        end
        else if (fire)
        begin
            turns_reg     <= turns_next;
            hold_reg      <= hold_next;
            cw_dir_reg    <= cw_dir_next;
            cw_ticks_reg  <= cw_ticks_next;
            ccw_ticks_reg <= ccw_ticks_next;
            moving_reg    <= moving_next;
            edge_cnt_reg  <= edge_cnt_next;
            edge_lim_reg  <= edge_lim_next;
            duty_reg      <= duty_next;
            level_reg     <= level_next;
        end
    end

    // Result shows the state after the tick
    always_comb
    begin
        res.forward_drive = moving_next && cw_dir_next;
        res.reverse_drive = moving_next && !cw_dir_next;
        res.drive_duty    = moving_next ? duty_next : 8'd0;
        res.turns_set     = turns_next;
        res.speed_level   = level_next;
        res.busy_res      = moving_next;
    end

    assign status.moving = moving_reg;
    assign status.hold   = hold_reg;

endmodule

// ----- hdl/motor_turn_count_controller_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_turn_count_controller_top
// Turn-count motor controller: tick register, controller core, result
// register and configuration registers.
// ----------------------------------------------------------------------------
// Every tick word gives exactly one result word. A word is captured in the
// tick register, passed through the core when the result register is free
// or being read (filter, speed band, debounce and edge count are all one
// pass of logic), and the result lands in the result register. One word
// per cycle is sustained while result.ready stays high. The tick register
// keeps taking words while a result waits, until both registers are full.
// Write configuration only while no word is in flight.
module motor_turn_count_controller_top (
    input  logic                            clk,
    input  logic                            rst_n,
    mtc_in_if.sink                          sample,
    mtc_out_if.source                       result,
    input  logic                            cfg_we,
    input  logic [mtc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mtc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    mtc_pkg::cfg_t    cfg;
    mtc_pkg::tick_t   tick_reg;
    mtc_pkg::res_t    res_comb;
    mtc_pkg::res_t    res_reg;
    mtc_pkg::status_t status;
    logic             tick_valid_reg, tick_valid_next;
    logic             res_valid_reg,  res_valid_next;
    logic             advance;
    logic             take;

    mtc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move the held word into the core when the result slot frees
    assign advance      = tick_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !tick_valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    mtc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .tick   (tick_reg),
        .cfg    (cfg),
        .res    (res_comb),
        .status (status)
    );

    always_comb
    begin
        tick_valid_next = tick_valid_reg;
        if (take)
            tick_valid_next = 1'b1;
        else if (advance)
            tick_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            tick_valid_reg <= tick_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Capture the tick word and the result word
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tick_reg.speed_sample <= sample.speed_sample;
            tick_reg.turns_sample <= sample.turns_sample;
            tick_reg.cw_switch    <= sample.cw_switch;
            tick_reg.ccw_switch   <= sample.ccw_switch;
            tick_reg.encoder_edge <= sample.encoder_edge;
        end
        if (advance)
            res_reg <= res_comb;
    end

    assign result.valid         = res_valid_reg;
    assign result.forward_drive = res_reg.forward_drive;
    assign result.reverse_drive = res_reg.reverse_drive;
    assign result.drive_duty    = res_reg.drive_duty;
    assign result.turns_set     = res_reg.turns_set;
    assign result.speed_level   = res_reg.speed_level;
    assign result.busy_res      = res_reg.busy_res;

`ifndef SYNTH
    // A move always runs under hold
    a_move_under_hold: assert property (@(posedge clk) disable iff (!rst_n)
        status.moving |-> status.hold)
        else $error("move running without hold");

    // Drive lines follow the busy flag and never both fire
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((result.forward_drive || result.reverse_drive) == result.busy_res)
                         && !(result.forward_drive && result.reverse_drive))
        else $error("drive lines disagree with busy");

    // Duty is zero when stopped
    a_duty_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.busy_res) |-> (result.drive_duty == 8'd0))
        else $error("duty while stopped");

    // Filtered turns stay within the pot range
    a_turns_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.turns_set <= 6'(mtc_pkg::MAX_TURNS)))
        else $error("turns out of range");
`endif

endmodule
